// File: hdl/ipv6tp_pkg.sv
// Shared types and constants for the IPv6 address text parser.
`timescale 1ns / 1ps
`default_nettype none
package ipv6tp_pkg;

  // Address shape
  localparam int NUM_GROUPS = 8;
  localparam int GROUP_W    = 16;
  localparam int GROUP_CW   = $clog2(NUM_GROUPS) + 1;
  localparam int GROUP_AW   = $clog2(NUM_GROUPS);
  localparam int MAX_DIGITS = 4;
  localparam int DIGIT_CW   = $clog2(MAX_DIGITS) + 1;
  localparam int HALF_W     = GROUP_W * NUM_GROUPS / 2;

  // Gap marker value meaning "no double colon seen"
  localparam logic [GROUP_CW-1:0] NO_GAP = GROUP_CW'(NUM_GROUPS);

  // Character codes
  localparam logic [7:0] END_CHAR   = 8'h00;
  localparam logic [7:0] COLON_CHAR = 8'h3A;

  // Token queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  // Character class handed from front to back
  typedef enum logic [1:0] {
    TK_END   = 2'd0,
    TK_COLON = 2'd1,
    TK_HEX   = 2'd2,
    TK_BAD   = 2'd3
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] nibble;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Colon tracking state
  typedef enum logic [3:0] {
    PH_START       = 4'b0001,  // start of text
    PH_AFTER_COLON = 4'b0010,  // single colon that closed a group
    PH_LEAD_COLON  = 4'b0100,  // colon at the very start
    PH_OTHER       = 4'b1000   // inside a group or after "::"
  } phase_t;

endpackage
`default_nettype wire

// File: hdl/ipv6tp_ifs.sv
// Valid/ready channel interfaces for the parser input and result.
`timescale 1ns / 1ps
`default_nettype none
interface ipv6tp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface ipv6tp_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  modport source (output valid, output ok, output addr_high, output addr_low, input ready);
  modport sink (input valid, input ok, input addr_high, input addr_low, output ready);
endinterface
`default_nettype wire

// File: hdl/ipv6tp_queue.sv
// Small token queue decoupling the classifier from the parser core.
`timescale 1ns / 1ps
`default_nettype none
module ipv6tp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ipv6tp_pkg::token_t    push_tok,
  input  logic                  pop,
  output ipv6tp_pkg::token_t    pop_tok,
  output ipv6tp_pkg::q_status_t status
);
  import ipv6tp_pkg::*;

  token_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;

  assign status.full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_tok      = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ipv6tp_front.sv
// Front end: accepts characters and classifies them into tokens.
`timescale 1ns / 1ps
`default_nettype none
module ipv6tp_front (
  ipv6tp_in_if.sink             in_ch,
  input  ipv6tp_pkg::q_status_t q_status,
  output logic                  push,
  output ipv6tp_pkg::token_t    push_tok
);
  import ipv6tp_pkg::*;

  logic [7:0] c;

  assign c           = in_ch.character;
  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && in_ch.ready;

  // Character class and hex digit value
  always_comb begin
    push_tok.nibble = 4'd0;
    case (c) inside
      END_CHAR: begin
        push_tok.kind = TK_END;
      end
      COLON_CHAR: begin
        push_tok.kind = TK_COLON;
      end
      [8'h30:8'h39]: begin
        push_tok.kind   = TK_HEX;
        push_tok.nibble = c[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        // 'A'/'a' carry 1 in the low nibble; add 9 for the value
        push_tok.kind   = TK_HEX;
        push_tok.nibble = c[3:0] + 4'd9;
      end
      default: begin
        push_tok.kind = TK_BAD;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/ipv6tp_back.sv
// Back end: parser state, group placement and result register.
`timescale 1ns / 1ps
`default_nettype none
module ipv6tp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipv6tp_pkg::token_t    tok,
  input  ipv6tp_pkg::q_status_t q_status,
  output logic                  pop,
  ipv6tp_out_if.source          out_ch
);
  import ipv6tp_pkg::*;

  // Parse state
  logic [GROUP_CW-1:0] cnt_r, cnt_nxt;
  logic [GROUP_W-1:0]  value_r, value_nxt;
  logic [DIGIT_CW-1:0] digits_r, digits_nxt;
  logic [GROUP_CW-1:0] gap_r, gap_nxt;
  phase_t              phase_r, phase_nxt;
  logic                err_r, err_nxt;

  // Groups before the gap sit at their own slot; groups after it shift in at the bottom
  logic [GROUP_W-1:0]  head_r [NUM_GROUPS];
  logic [GROUP_W-1:0]  head_nxt [NUM_GROUPS];
  logic [GROUP_W-1:0]  tail_r [NUM_GROUPS];
  logic [GROUP_W-1:0]  tail_nxt [NUM_GROUPS];
  logic [GROUP_W-1:0]  tail_shift [NUM_GROUPS];

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [HALF_W-1:0]   out_hi_r, out_hi_nxt;
  logic [HALF_W-1:0]   out_lo_r, out_lo_nxt;

  logic                out_free;
  logic                end_tok;
  logic                has_digits;
  logic [GROUP_CW-1:0] cnt_fin;
  logic                fin_ok;
  logic [GROUP_W-1:0]  fin_grp [NUM_GROUPS];

  assign out_free   = !out_valid_r || out_ch.ready;
  assign end_tok    = (tok.kind == TK_END);
  assign pop        = !q_status.empty && (!end_tok || out_free);
  assign has_digits = (digits_r != '0);
  assign cnt_fin    = has_digits ? cnt_r + 1'b1 : cnt_r;

  // Tail with the group being read shifted in at the bottom
  always_comb begin
    for (int i = 0; i < NUM_GROUPS - 1; i++) begin
      tail_shift[i] = tail_r[i+1];
    end
    tail_shift[NUM_GROUPS-1] = value_r;
  end

  // End-of-text verdict
  always_comb begin
    fin_ok = !err_r && (cnt_r < NO_GAP) && (phase_r != PH_LEAD_COLON)
             && (has_digits || (gap_r == cnt_r));
    if (gap_r == NO_GAP) begin
      fin_ok = fin_ok && (cnt_fin == NO_GAP);
    end else begin
      fin_ok = fin_ok && (cnt_fin != NO_GAP);
    end
  end

  // Final group layout including the group still being read
  always_comb begin
    for (int i = 0; i < NUM_GROUPS; i++) begin
      fin_grp[i] = head_r[i];
      if (gap_r == NO_GAP) begin
        if (has_digits && (cnt_r[GROUP_AW-1:0] == GROUP_AW'(i))) begin
          fin_grp[i] = value_r;
        end
      end else if (has_digits) begin
        fin_grp[i] = head_r[i] | tail_shift[i];
      end else begin
        fin_grp[i] = head_r[i] | tail_r[i];
      end
    end
  end

  // Token processing
  always_comb begin
    cnt_nxt    = cnt_r;
    value_nxt  = value_r;
    digits_nxt = digits_r;
    gap_nxt    = gap_r;
    phase_nxt  = phase_r;
    err_nxt    = err_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;

    if (pop) begin
      if (end_tok) begin
        cnt_nxt    = '0;
        value_nxt  = '0;
        digits_nxt = '0;
        gap_nxt    = NO_GAP;
        phase_nxt  = PH_START;
        err_nxt    = 1'b0;
        for (int i = 0; i < NUM_GROUPS; i++) begin
          head_nxt[i] = '0;
          tail_nxt[i] = '0;
        end
      end else if (!err_r) begin
        if (cnt_r >= NO_GAP) begin
          err_nxt = 1'b1;
        end else begin
          case (tok.kind)
            TK_COLON: begin
              case (phase_r)
                PH_START: begin
                  phase_nxt = PH_LEAD_COLON;
                end
                PH_AFTER_COLON, PH_LEAD_COLON: begin
                  if (gap_r != NO_GAP) begin
                    err_nxt = 1'b1;
                  end else begin
                    gap_nxt   = cnt_r;
                    phase_nxt = PH_OTHER;
                  end
                end
                PH_OTHER: begin
                  if (!has_digits) begin
                    err_nxt = 1'b1;
                  end else begin
                    // close the group
                    if (gap_r == NO_GAP) begin
                      head_nxt[cnt_r[GROUP_AW-1:0]] = value_r;
                    end else begin
                      tail_nxt = tail_shift;
                    end
                    cnt_nxt    = cnt_r + 1'b1;
                    value_nxt  = '0;
                    digits_nxt = '0;
                    phase_nxt  = PH_AFTER_COLON;
                  end
                end
                default: begin
                  err_nxt = 1'b1;
                end
              endcase
            end
            TK_HEX: begin
              if ((phase_r == PH_LEAD_COLON) || (digits_r >= DIGIT_CW'(MAX_DIGITS))) begin
                err_nxt = 1'b1;
              end else begin
                value_nxt  = {value_r[GROUP_W-5:0], tok.nibble};
                digits_nxt = digits_r + 1'b1;
                phase_nxt  = PH_OTHER;
              end
            end
            default: begin
              err_nxt = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // Result register load and drain
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_hi_nxt    = out_hi_r;
    out_lo_nxt    = out_lo_r;
    if (pop && end_tok) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = fin_ok;
      out_hi_nxt    = fin_ok ? {fin_grp[0], fin_grp[1], fin_grp[2], fin_grp[3]} : '0;
      out_lo_nxt    = fin_ok ? {fin_grp[4], fin_grp[5], fin_grp[6], fin_grp[7]} : '0;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      value_r     <= '0;
      digits_r    <= '0;
      gap_r       <= NO_GAP;
      phase_r     <= PH_START;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      cnt_r       <= cnt_nxt;
      value_r     <= value_nxt;
      digits_r    <= digits_nxt;
      gap_r       <= gap_nxt;
      phase_r     <= phase_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_ok_r <= out_ok_nxt;
    out_hi_r <= out_hi_nxt;
    out_lo_r <= out_lo_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.ok        = out_ok_r;
  assign out_ch.addr_high = out_hi_r;
  assign out_ch.addr_low  = out_lo_r;

endmodule
`default_nettype wire

// File: hdl/ipv6_text_address_parser.sv
// Top level of the IPv6 address text parser.
//
//   channel  | dir | payload                              | transaction
//   ---------+-----+--------------------------------------+------------------------------
//   in_ch    | in  | character[7:0]                       | one text byte, zero ends text
//   out_ch   | out | ok, addr_high[63:0], addr_low[63:0]  | one per zero byte
//
// One character per cycle while in_ch.ready is high; each token updates the parse state when popped.
// With the queue empty, a zero byte is written into the queue, then popped into the result register once it is free.
// Reset is synchronous and clears all parse state at once; no clearing pass.
// A stalled result parks its zero byte at the queue head; three more characters
// queue behind it, then in_ch.ready drops until the result drains.
`timescale 1ns / 1ps
`default_nettype none
module ipv6_text_address_parser (
  input  logic         clk,
  input  logic         rst_n,
  ipv6tp_in_if.sink    in_ch,
  ipv6tp_out_if.source out_ch
);
  import ipv6tp_pkg::*;

  logic      push;
  token_t    push_tok;
  logic      pop;
  token_t    tok;
  q_status_t q_status;

  ipv6tp_front u_front (
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_tok (push_tok)
  );

  ipv6tp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .pop_tok  (tok),
    .status   (q_status)
  );

  ipv6tp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok      (tok),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // Non-terminating tokens never wait on the result side
  ap_no_char_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_status.empty && (tok.kind != TK_END)) |-> pop)
    else $error("character token stalled in queue");

  // An accepted transaction is queued by the next cycle
  ap_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !q_status.empty)
    else $error("accepted character missing from queue");

  // A consumed end token produces a result
  ap_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (tok.kind == TK_END)) |=> out_ch.valid)
    else $error("end of text without result");

endmodule
`default_nettype wire
